// File: rtl/glcr_pkg.sv
// Shared types and constants for the GIF loop-count rewriter.
// Used by glcr_front, glcr_queue, glcr_back and gif_loop_count_rewriter.
package glcr_pkg;

  // Header geometry
  localparam int HDR_LEN     = 16;
  localparam int SKIP_LEN    = 3;
  localparam int HDR_IDX_W   = $clog2(HDR_LEN);
  localparam int HOLD_W      = $clog2(HDR_LEN + SKIP_LEN + 1);
  localparam int RES_IDX_W   = $clog2(HDR_LEN + 4);

  // Hold counts at which the replacement is due and at which the header ends
  localparam logic [HOLD_W-1:0] HOLD_DROP_END = HOLD_W'(HDR_LEN + SKIP_LEN);
  localparam logic [HOLD_W-1:0] HOLD_HDR_END  = HOLD_W'(HDR_LEN);

  // Positions inside a replacement burst
  localparam logic [RES_IDX_W-1:0] RES_CNT_LO = RES_IDX_W'(HDR_LEN);
  localparam logic [RES_IDX_W-1:0] RES_CNT_HI = RES_IDX_W'(HDR_LEN + 1);
  localparam logic [RES_IDX_W-1:0] RES_TERM   = RES_IDX_W'(HDR_LEN + 2);
  localparam logic [RES_IDX_W-1:0] RES_LAST   = RES_IDX_W'(HDR_LEN + 3);

  // Command queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Animation looping application-extension header
  localparam logic [7:0] LOOP_HDR [HDR_LEN] = '{
    8'h21, 8'hFF, 8'h0B, 8'h4E, 8'h45, 8'h54, 8'h53, 8'h43,
    8'h41, 8'h50, 8'h45, 8'h32, 8'h2E, 8'h30, 8'h03, 8'h01
  };

  // Comment-extension header used when the loop count is zero
  localparam logic [7:0] CMT_HDR [HDR_LEN] = '{
    8'h21, 8'hFE, 8'h0B, 8'h58, 8'h58, 8'h58, 8'h58, 8'h58,
    8'h58, 8'h58, 8'h58, 8'h31, 8'h2E, 8'h30, 8'h03, 8'h01
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef enum logic {
    CMD_PASS,
    CMD_REPL
  } cmd_kind_t;

  // One unit of back-end work: a flush of held prefix plus byte, or a replacement
  typedef struct packed {
    cmd_kind_t            kind;
    logic [HDR_IDX_W-1:0] held;
    logic [7:0]           data;
  } cmd_t;

endpackage

// File: rtl/glcr_front.sv
// Front end: tracks the header match and classifies each accepted byte.
// Depends on glcr_pkg; pushes commands into glcr_queue.
module glcr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  glcr_pkg::in_item_t byte_req,
  input  logic              q_full,
  output logic              q_push,
  output glcr_pkg::cmd_t    q_cmd
);
  import glcr_pkg::*;

  logic [HOLD_W-1:0] hold;
  logic [HOLD_W-1:0] hold_eff;
  logic [HOLD_W-1:0] hold_next;
  logic              emit;
  logic              accept;

  // Stall whenever the queue has no room
  assign byte_stall = q_full;
  assign accept     = byte_valid && !q_full;
  assign q_push     = accept && emit;

  // Classify the byte against the current hold
  always_comb begin
    hold_eff     = byte_req.new_stream ? '0 : hold;
    hold_next    = hold_eff;
    emit         = 1'b0;
    q_cmd.kind   = CMD_PASS;
    q_cmd.held   = '0;
    q_cmd.data   = byte_req.data_byte;
    if (hold_eff >= HOLD_DROP_END) begin
      emit       = 1'b1;
      q_cmd.kind = CMD_REPL;
      hold_next  = '0;
    end else if (hold_eff >= HOLD_HDR_END) begin
      hold_next = hold_eff + 1'b1;
    end else if (hold_eff != '0) begin
      if (byte_req.data_byte == LOOP_HDR[hold_eff[HDR_IDX_W-1:0]]) begin
        hold_next = hold_eff + 1'b1;
      end else begin
        emit       = 1'b1;
        q_cmd.held = hold_eff[HDR_IDX_W-1:0];
        hold_next  = '0;
      end
    end else begin
      if (byte_req.data_byte == LOOP_HDR[0]) begin
        hold_next = HOLD_W'(1);
      end else begin
        emit = 1'b1;
      end
    end
  end

  // Advance the hold on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= '0;
    end else if (accept) begin
      hold <= hold_next;
    end
  end

  a_hold_range: assert property (@(posedge clk) disable iff (rst)
    hold <= HOLD_DROP_END)
    else $error("hold count beyond the drop window");

endmodule

// File: rtl/glcr_queue.sv
// Short command queue between the front and back ends.
// Depends on glcr_pkg for the command type and depth.
module glcr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  glcr_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output glcr_pkg::cmd_t head,
  output logic           empty
);
  import glcr_pkg::*;

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] cnt;

  assign full  = (cnt == QCNT_W'(QUEUE_DEPTH));
  assign empty = (cnt == '0);
  assign head  = mem[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into a full command queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from an empty command queue");

endmodule

// File: rtl/glcr_back.sv
// Back end: expands queued commands into output bytes and holds the loop count.
// Depends on glcr_pkg; pops commands from glcr_queue.
module glcr_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data,
  input  logic                q_empty,
  input  glcr_pkg::cmd_t      q_head,
  output logic                q_pop,
  output logic                filt_valid,
  input  logic                filt_stall,
  output glcr_pkg::out_item_t filt_req
);
  import glcr_pkg::*;

  logic [15:0]          loop_count;
  logic                 busy;
  cmd_t                 cmd;
  logic [RES_IDX_W-1:0] idx;
  logic [RES_IDX_W-1:0] last_idx;
  logic [7:0]           cur_byte;
  logic                 advance;

  assign cfg_ready = 1'b1;
  assign q_pop     = !busy && !q_empty;
  assign advance   = busy && (!filt_valid || !filt_stall);
  assign last_idx  = (cmd.kind == CMD_REPL) ? RES_LAST : RES_IDX_W'(cmd.held);

  // Select the byte at the current burst position
  always_comb begin
    cur_byte = cmd.data;
    if (cmd.kind == CMD_REPL) begin
      case (idx)
        RES_CNT_LO: cur_byte = loop_count[7:0];
        RES_CNT_HI: cur_byte = loop_count[15:8];
        RES_TERM:   cur_byte = 8'h00;
        RES_LAST:   cur_byte = cmd.data;
        default: begin
          cur_byte = (loop_count != 16'h0000) ? LOOP_HDR[idx[HDR_IDX_W-1:0]]
                                              : CMT_HDR[idx[HDR_IDX_W-1:0]];
        end
      endcase
    end else if (idx != last_idx) begin
      cur_byte = LOOP_HDR[idx[HDR_IDX_W-1:0]];
    end
  end

  // Hold the loop count register
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_count <= 16'h0001;
    end else if (cfg_valid && cfg_ready) begin
      loop_count <= cfg_data;
    end
  end

  // Load commands, step through bursts, drive the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      filt_valid <= 1'b0;
      idx        <= '0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
        cmd  <= q_head;
        idx  <= '0;
      end
      if (advance) begin
        filt_valid        <= 1'b1;
        filt_req.out_byte <= cur_byte;
        filt_req.last     <= (idx == last_idx);
        idx               <= idx + 1'b1;
        if (idx == last_idx) begin
          busy <= 1'b0;
        end
      end else if (filt_valid && !filt_stall) begin
        filt_valid <= 1'b0;
      end
    end
  end

  a_idx_in_burst: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= last_idx)
    else $error("burst position past the end of its command");

endmodule

// File: rtl/gif_loop_count_rewriter.sv
// Top level of the GIF loop-count rewriter: front end, command queue, back end.
// Depends on glcr_pkg, glcr_front, glcr_queue and glcr_back.
//
//   channel   signals                          payload
//   byte      byte_valid / byte_stall          byte_req  (data_byte, new_stream)
//   filt      filt_valid / filt_stall          filt_req  (out_byte, last)
//   cfg       cfg_valid / cfg_ready            cfg_data  (loop_count)
//
// The front end takes one input byte per cycle while the command queue has room.
// The back end loads a command only while idle, then emits its output bytes,
// stalled by filt_stall: 1 to 16 bytes for a flush, 20 for a replacement.
// Bytes that are matched or dropped produce no command.
// Reset is synchronous; it empties the queue, clears the match hold and sets
// the loop count to 1. cfg_ready is always high.
module gif_loop_count_rewriter (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  glcr_pkg::in_item_t  byte_req,
  output logic                filt_valid,
  input  logic                filt_stall,
  output glcr_pkg::out_item_t filt_req,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);
  import glcr_pkg::*;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t q_cmd;
  cmd_t q_head;

  glcr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_req   (byte_req),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  glcr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  glcr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .filt_valid (filt_valid),
    .filt_stall (filt_stall),
    .filt_req   (filt_req)
  );

endmodule

// File: tb/tb_gif_loop_count_rewriter.sv
// Testbench for gif_loop_count_rewriter: drives byte requests, predicts the filtered
// stream in a local model of the header matcher, and checks every output request.
// Depends on glcr_pkg and the RTL of gif_loop_count_rewriter.
module tb_gif_loop_count_rewriter;
  timeunit 1ns;
  timeprecision 1ps;

  import glcr_pkg::*;

  localparam int IDLE_PCT        = 15;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int END_CYCLES      = 30;

  // Header that enables looping, and the comment header that replaces it for a zero count
  localparam logic [7:0] APP_LOOP_HDR [16] = '{
    8'h21, 8'hFF, 8'h0B, 8'h4E, 8'h45, 8'h54, 8'h53, 8'h43,
    8'h41, 8'h50, 8'h45, 8'h32, 8'h2E, 8'h30, 8'h03, 8'h01
  };
  localparam logic [7:0] COMMENT_HDR [16] = '{
    8'h21, 8'hFE, 8'h0B, 8'h58, 8'h58, 8'h58, 8'h58, 8'h58,
    8'h58, 8'h58, 8'h58, 8'h31, 8'h2E, 8'h30, 8'h03, 8'h01
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  in_item_t    byte_req = '0;
  logic        filt_valid;
  logic        filt_stall = 1'b0;
  out_item_t   filt_req;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  // Local copy of the matcher state and the loop count register
  logic [4:0]  match_len = '0;
  logic [15:0] loop_cnt = 16'd1;
  out_item_t   pending_out [$];

  bit steady = 1'b0;
  int hold_off_reqs = 0;
  int hold_off_seen = 0;
  int hold_off_left = 0;
  int idle_cycles = 0;
  int n_errors = 0;
  int n_in = 0;
  int n_out = 0;
  int n_replace = 0;
  int n_flush = 0;
  int n_cfg = 0;

  gif_loop_count_rewriter DUT (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_req   (byte_req),
    .filt_valid (filt_valid),
    .filt_stall (filt_stall),
    .filt_req   (filt_req),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the matcher by one byte and queue the output bytes it releases
  function automatic void predict_filter(input in_item_t req);
    logic [7:0] burst [$];
    out_item_t res;
    if (req.new_stream) match_len = '0;
    if (match_len >= HDR_LEN + SKIP_LEN) begin
      for (int i = 0; i < HDR_LEN; i++)
        burst.push_back(loop_cnt != 16'd0 ? APP_LOOP_HDR[i] : COMMENT_HDR[i]);
      burst.push_back(loop_cnt[7:0]);
      burst.push_back(loop_cnt[15:8]);
      burst.push_back(8'h00);
      burst.push_back(req.data_byte);
      match_len = '0;
      n_replace++;
    end else if (match_len >= HDR_LEN) begin
      match_len++;
    end else if (match_len > 0) begin
      if (req.data_byte == APP_LOOP_HDR[match_len[3:0]]) begin
        match_len++;
      end else begin
        // Release the held prefix; the breaking byte is not rescanned
        for (int i = 0; i < match_len; i++) burst.push_back(APP_LOOP_HDR[i]);
        burst.push_back(req.data_byte);
        match_len = '0;
        n_flush++;
      end
    end else if (req.data_byte == APP_LOOP_HDR[0]) begin
      match_len = 5'd1;
    end else begin
      burst.push_back(req.data_byte);
    end
    foreach (burst[i]) begin
      res.out_byte = burst[i];
      res.last = (i == burst.size() - 1);
      pending_out.push_back(res);
    end
  endfunction

  function automatic void check_filter_out(input out_item_t got);
    out_item_t want;
    if (pending_out.size() == 0) begin
      $error("unexpected request: out_byte %02h last %0b", got.out_byte, got.last);
      n_errors++;
    end else begin
      want = pending_out.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
        n_errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, got.last);
        n_errors++;
      end
    end
  endfunction

  // Check output requests and drive the receiver's stall
  always @(posedge clk) begin
    if (!rst && filt_valid && !filt_stall) begin
      check_filter_out(filt_req);
      n_out++;
    end
    if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      filt_stall <= 1'b1;
    end else if (hold_off_seen != hold_off_reqs) begin
      hold_off_seen <= hold_off_reqs;
      hold_off_left <= HOLD_OFF_CYCLES;
      filt_stall <= 1'b1;
    end else begin
      filt_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (filt_valid && !filt_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no request moved in %0d cycles", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic ns);
    in_item_t req;
    req.data_byte = b;
    req.new_stream = ns;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_req <= req;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    predict_filter(req);
    n_in++;
  endtask

  // Drop valid and wait until every queued output byte has come back
  task automatic wait_drained();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_loop_count(input logic [15:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    loop_cnt = value;
    n_cfg++;
    cfg_valid <= 1'b0;
  endtask

  task automatic send_header_prefix(input int len);
    for (int i = 0; i < len; i++) send_byte(APP_LOOP_HDR[i], 1'b0);
  endtask

  // Whole header, three dropped bytes, then the byte that triggers the rewrite
  task automatic send_full_header(input logic [7:0] tail, input logic tail_ns);
    send_header_prefix(HDR_LEN);
    for (int i = 0; i < SKIP_LEN; i++) send_byte(8'($urandom_range(255)), 1'b0);
    send_byte(tail, tail_ns);
  endtask

  task automatic send_random_chunk();
    int pick;
    int len;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_full_header(8'($urandom_range(255)), $urandom_range(9) == 0);
    end else if (pick < 70) begin
      // Partial header broken by a wrong byte
      len = $urandom_range(1, HDR_LEN - 1);
      send_header_prefix(len);
      if ($urandom_range(3) == 0) b = APP_LOOP_HDR[0];
      else begin
        do b = 8'($urandom_range(255)); while (b == APP_LOOP_HDR[len]);
      end
      send_byte(b, 1'b0);
    end else if (pick < 85) begin
      // Start a new stream while matching or dropping
      len = $urandom_range(1, HDR_LEN + SKIP_LEN);
      send_header_prefix(len < HDR_LEN ? len : HDR_LEN);
      for (int i = HDR_LEN; i < len; i++) send_byte(8'($urandom_range(255)), 1'b0);
      send_byte($urandom_range(3) == 0 ? APP_LOOP_HDR[0] : 8'($urandom_range(255)), 1'b1);
    end else begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        b = ($urandom_range(9) == 0) ? APP_LOOP_HDR[0] : 8'($urandom_range(255));
        send_byte(b, $urandom_range(19) == 0);
      end
    end
  endtask

  // Plain bytes at the field extremes, and a start byte that is not rescanned
  task automatic test_plain_bytes();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h21, 1'b0);
    send_byte(8'h21, 1'b0);
    send_byte(8'h21, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  // Rewrite with the reset loop count; the tail byte is a header start
  task automatic test_replacement();
    send_full_header(8'h21, 1'b0);
    send_byte(8'h3B, 1'b0);
  endtask

  // Longest flush: fifteen held bytes plus the breaking byte
  task automatic test_long_flush();
    send_header_prefix(HDR_LEN - 1);
    send_byte(8'h00, 1'b0);
  endtask

  // New stream discards a held prefix and a pending rewrite
  task automatic test_new_stream();
    send_header_prefix(5);
    send_byte(8'h21, 1'b1);
    send_byte(8'h7E, 1'b0);
    send_header_prefix(HDR_LEN);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'hC3, 1'b1);
  endtask

  // Hold the receiver off while headers and plain bytes keep arriving, so the
  // command queue fills and the input stalls
  task automatic test_output_hold_off();
    hold_off_reqs++;
    steady = 1'b1;
    for (int i = 0; i < 3; i++) send_full_header(8'($urandom_range(255)), 1'b0);
    for (int i = 0; i < 4; i++) send_byte(8'h40 + 8'(i), 1'b0);
    steady = 1'b0;
  endtask

  task automatic test_random_traffic(input logic [15:0] count, input int n_items,
                                     input bit no_idle);
    int target;
    write_loop_count(count);
    steady = no_idle;
    target = n_in + n_items;
    while (n_in < target) send_random_chunk();
    steady = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_plain_bytes();
    test_replacement();
    test_long_flush();
    test_new_stream();
    test_output_hold_off();
    test_random_traffic(16'h0000, 50, 1'b0);
    test_random_traffic(16'hFFFF, 50, 1'b0);
    test_random_traffic(16'($urandom_range(2, 16'hFFFE)), 50, 1'b1);
    test_random_traffic(16'h0001, 50, 1'b0);
    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    $display("covered %0d input bytes, %0d output bytes, %0d rewrites, %0d flushes",
             n_in, n_out, n_replace, n_flush);
    $display("loop count written %0d times, zero and all-ones included", n_cfg);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
